// ===== rtl/tcp_pkg.sv =====
package tcp_pkg;

   localparam int COLS = 80;
   localparam int ROWS = 25;
   localparam int CELLS = COLS * ROWS;
   localparam int LAST_ROW_BASE = COLS * (ROWS - 1);

   localparam int COL_W = 7;
   localparam int ROW_W = 5;
   localparam int ADDR_W = 11;
   localparam int CNT_W = $clog2(CELLS + 1);

   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam int TAB_STEP = 8;

   localparam logic OP_PUT = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic CSR_TEXT_ATTR = 1'b0;
   localparam logic CSR_BLANK_ATTR = 1'b1;

   localparam logic [7:0] TEXT_ATTR_RESET = 8'h04;
   localparam logic [7:0] BLANK_ATTR_RESET = 8'h0F;

   typedef struct packed {
      logic operation;
      logic [7:0] char_code;
      logic [ADDR_W-1:0] cell_address;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] cell_data;
      logic [COL_W-1:0] cursor_col;
      logic [ROW_W-1:0] cursor_row;
      logic [ADDR_W-1:0] cursor_offset;
      logic scrolled;
   } rsp_payload_type;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE = 6'b000010,
      ST_READ = 6'b000100,
      ST_COPY = 6'b001000,
      ST_FILL = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   typedef struct packed {
      logic clear_wr;
      logic put_accept;
      logic read_issue;
      logic capture_read;
      logic copy_step;
      logic fill_step;
      logic cnt_clr;
      logic cnt_inc;
      logic load_fast;
      logic load_done;
   } dp_cmd_type;

   typedef struct packed {
      logic will_scroll;
      logic clear_end;
      logic copy_end;
      logic fill_end;
   } dp_status_type;

   function automatic logic [ADDR_W-1:0] cell_offset(logic [ROW_W-1:0] row,
                                                     logic [COL_W-1:0] col);
      return ADDR_W'(ADDR_W'(row) * ADDR_W'(COLS)) + ADDR_W'(col);
   endfunction

endpackage

// ===== rtl/tcp_ctrl.sv =====
module tcp_ctrl import tcp_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_operation,
   output logic req_stall,
   output logic rsp_valid,
   input logic rsp_stall,
   input dp_status_type status,
   output dp_cmd_type cmd
);

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   // The output slot can take a new result when empty or when its item leaves now.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (status.clear_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == OP_READ) begin
                  cmd.read_issue = 1'b1;
                  state_in = ST_READ;
               end else begin
                  cmd.put_accept = 1'b1;
                  if (status.will_scroll) begin
                     cmd.cnt_clr = 1'b1;
                     state_in = ST_COPY;
                  end else if (out_free) begin
                     cmd.load_fast = 1'b1;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_READ: begin
            cmd.capture_read = 1'b1;
            state_in = ST_DONE;
         end
         ST_COPY: begin
            cmd.copy_step = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (status.copy_end) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (status.fill_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_done = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_fast || cmd.load_done) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/tcp_datapath.sv =====
module tcp_datapath import tcp_pkg::*; (
   input logic clock,
   input logic reset,
   input req_payload_type req_payload,
   output rsp_payload_type rsp_payload,
   input logic csr_write_enable,
   input logic csr_index,
   input logic [7:0] csr_wdata,
   input dp_cmd_type cmd,
   output dp_status_type status
);

   logic [15:0] screen_mem [CELLS];
   logic [15:0] rd_data_ff;

   logic [7:0] text_attr_ff, text_attr_in;
   logic [7:0] blank_attr_ff, blank_attr_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic in_range_ff;
   logic [15:0] data_ff;
   logic scroll_ff;
   rsp_payload_type rsp_ff;

   logic [7:0] col_t;
   logic [ROW_W:0] row_t;
   logic [COL_W-1:0] col_next;
   logic [ROW_W-1:0] row_next;
   logic ordinary;
   logic rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [15:0] wr_data;
   logic [ADDR_W-1:0] cnt_addr;
   logic [ADDR_W-1:0] cnt_prev;

   assign ordinary = (req_payload.char_code != CHAR_BACKSPACE) &&
                     (req_payload.char_code != CHAR_TAB) &&
                     (req_payload.char_code != CHAR_NEWLINE);

   // Cursor movement for a put item, before the scroll check.
   always_comb begin
      col_t = 8'(col_ff);
      row_t = (ROW_W+1)'(row_ff);
      case (req_payload.char_code)
         CHAR_BACKSPACE: begin
            if (col_ff == '0) begin
               if (row_ff != '0) begin
                  col_t = 8'(COLS - 1);
                  row_t = (ROW_W+1)'(row_ff) - 1'b1;
               end
            end else begin
               col_t = 8'(col_ff) - 1'b1;
            end
         end
         CHAR_TAB: begin
            if (8'(col_ff) + 8'(TAB_STEP) >= 8'(COLS)) begin
               col_t = 8'(col_ff) + 8'(TAB_STEP) - 8'(COLS);
               row_t = (ROW_W+1)'(row_ff) + 1'b1;
            end else begin
               col_t = 8'(col_ff) + 8'(TAB_STEP);
            end
         end
         CHAR_NEWLINE: begin
            row_t = (ROW_W+1)'(row_ff) + 1'b1;
         end
         default: begin
            col_t = 8'(col_ff) + 1'b1;
         end
      endcase
      if (col_t >= 8'(COLS)) begin
         col_t = '0;
         row_t = row_t + 1'b1;
      end
   end

   assign status.will_scroll = (row_t >= (ROW_W+1)'(ROWS));
   assign col_next = status.will_scroll ? '0 : col_t[COL_W-1:0];
   assign row_next = status.will_scroll ? ROW_W'(ROWS - 1) : row_t[ROW_W-1:0];

   assign status.clear_end = (cnt_ff == CNT_W'(CELLS - 1));
   assign status.copy_end = (cnt_ff == CNT_W'(LAST_ROW_BASE));
   assign status.fill_end = (cnt_ff == CNT_W'(CELLS));

   assign cnt_addr = cnt_ff[ADDR_W-1:0];
   assign cnt_prev = cnt_addr - 1'b1;

   // Read port: a read item, or the row below during the scroll copy.
   always_comb begin
      rd_en = 1'b0;
      rd_addr = req_payload.cell_address;
      if (cmd.read_issue) begin
         rd_en = (req_payload.cell_address < ADDR_W'(CELLS));
      end else if (cmd.copy_step && (cnt_ff < CNT_W'(LAST_ROW_BASE))) begin
         rd_en = 1'b1;
         rd_addr = cnt_addr + ADDR_W'(COLS);
      end
   end

   // Write port. The copy writes one cell behind its read, since the read data is registered.
   always_comb begin
      wr_en = 1'b0;
      wr_addr = cnt_addr;
      wr_data = '0;
      if (cmd.clear_wr) begin
         wr_en = 1'b1;
      end else if (cmd.put_accept) begin
         wr_en = ordinary;
         wr_addr = cell_offset(row_ff, col_ff);
         wr_data = {text_attr_ff, req_payload.char_code};
      end else if (cmd.copy_step) begin
         wr_en = (cnt_ff != '0);
         wr_addr = cnt_prev;
         wr_data = rd_data_ff;
      end else if (cmd.fill_step) begin
         wr_en = 1'b1;
         wr_addr = cnt_prev;
         wr_data = {blank_attr_ff, CHAR_SPACE};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         screen_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= screen_mem[rd_addr];
      end
   end

   always_comb begin
      text_attr_in = text_attr_ff;
      blank_attr_in = blank_attr_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_TEXT_ATTR: text_attr_in = csr_wdata;
            CSR_BLANK_ATTR: blank_attr_in = csr_wdata;
            default: text_attr_in = text_attr_ff;
         endcase
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.put_accept) begin
         col_in = col_next;
         row_in = row_next;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_attr_ff <= TEXT_ATTR_RESET;
         blank_attr_ff <= BLANK_ATTR_RESET;
         col_ff <= '0;
         row_ff <= '0;
         cnt_ff <= '0;
      end else begin
         text_attr_ff <= text_attr_in;
         blank_attr_ff <= blank_attr_in;
         col_ff <= col_in;
         row_ff <= row_in;
         cnt_ff <= cnt_in;
      end
   end

   // Result fields of the item in flight, held until the output slot is free.
   always_ff @(posedge clock) begin
      if (cmd.read_issue) begin
         in_range_ff <= (req_payload.cell_address < ADDR_W'(CELLS));
      end
      if (cmd.put_accept) begin
         data_ff <= '0;
         scroll_ff <= status.will_scroll;
      end else if (cmd.capture_read) begin
         data_ff <= in_range_ff ? rd_data_ff : '0;
         scroll_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_fast) begin
         rsp_ff.cell_data <= '0;
         rsp_ff.cursor_col <= col_next;
         rsp_ff.cursor_row <= row_next;
         rsp_ff.cursor_offset <= cell_offset(row_next, col_next);
         rsp_ff.scrolled <= 1'b0;
      end else if (cmd.load_done) begin
         rsp_ff.cell_data <= data_ff;
         rsp_ff.cursor_col <= col_ff;
         rsp_ff.cursor_row <= row_ff;
         rsp_ff.cursor_offset <= cell_offset(row_ff, col_ff);
         rsp_ff.scrolled <= scroll_ff;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/text_console_put_char.sv =====
// Put items that do not scroll load their result directly when the output slot is free, else
// through the done state; one per cycle while the output slot stays free. Read items go
// through a memory read, a registered data capture and an output load. A scroll copies the
// store one cell a cycle through the memory's read and write ports and refills the last
// row while input is stalled. Reset is synchronous and active high; it starts a clearing pass
// that zeroes the store while input is stalled. Configuration writes are taken outside reset.
module text_console_put_char import tcp_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input req_payload_type req_payload,
   output logic rsp_valid,
   input logic rsp_stall,
   output rsp_payload_type rsp_payload,
   input logic csr_write_enable,
   input logic csr_index,
   input logic [7:0] csr_wdata
);

   dp_cmd_type cmd;
   dp_status_type status;

   tcp_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_operation(req_payload.operation),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .status(status),
      .cmd(cmd)
   );

   tcp_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .req_payload(req_payload),
      .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cmd(cmd),
      .status(status)
   );

endmodule

// ===== rtl/tcp_checker.sv =====
module tcp_checker import tcp_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input rsp_payload_type rsp_payload
);

   // A result waiting on a stalled receiver stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // Reset starts the clearing pass, so no item can enter and no result is shown.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("input open or result shown right after reset");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.cursor_col < COL_W'(COLS)) &&
                    (rsp_payload.cursor_row < ROW_W'(ROWS)))
      else $error("cursor out of screen");

   a_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.cursor_offset ==
                    cell_offset(rsp_payload.cursor_row, rsp_payload.cursor_col))
      else $error("cursor offset disagrees with row and column");

   // A scroll always leaves the cursor at the start of the last row.
   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.scrolled |->
         (rsp_payload.cursor_col == '0) && (rsp_payload.cursor_row == ROW_W'(ROWS - 1)))
      else $error("scroll left the cursor elsewhere");

endmodule

bind text_console_put_char tcp_checker u_checker (
   .clock(clock),
   .reset(reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_payload(rsp_payload)
);

// ===== verif/tb_text_console_put_char.sv =====
`timescale 1ns / 1ps

module tb_text_console_put_char;
   import tcp_pkg::*;

   // Mirror of the console: screen store, cursor and attributes, plus the reports that
   // the block still owes for accepted items.
   class console_mirror;
      logic [15:0] cells [CELLS];
      int unsigned col;
      int unsigned row;
      logic [7:0] text_attr;
      logic [7:0] blank_attr;
      rsp_payload_type pending_reports [$];
      int unsigned errors;

      function new();
         foreach (cells[i]) cells[i] = 16'h0000;
         col = 0;
         row = 0;
         text_attr = TEXT_ATTR_RESET;
         blank_attr = BLANK_ATTR_RESET;
         errors = 0;
      endfunction

      function void apply_item(req_payload_type item);
         rsp_payload_type report;
         report = '0;
         if (item.operation == OP_READ) begin
            if (item.cell_address < CELLS) begin
               report.cell_data = cells[item.cell_address];
            end
         end else begin
            case (item.char_code)
               CHAR_BACKSPACE: begin
                  if (col != 0) begin
                     col--;
                  end else if (row != 0) begin
                     col = COLS - 1;
                     row--;
                  end
               end
               CHAR_TAB: begin
                  if (col + TAB_STEP >= COLS) begin
                     col = col + TAB_STEP - COLS;
                     row++;
                  end else begin
                     col += TAB_STEP;
                  end
               end
               CHAR_NEWLINE: begin
                  row++;
               end
               default: begin
                  cells[row * COLS + col] = {text_attr, item.char_code};
                  col++;
               end
            endcase
            if (col >= COLS) begin
               col = 0;
               row++;
            end
            if (row >= ROWS) begin
               for (int i = 0; i < LAST_ROW_BASE; i++) cells[i] = cells[i + COLS];
               for (int i = LAST_ROW_BASE; i < CELLS; i++) cells[i] = {blank_attr, CHAR_SPACE};
               col = 0;
               row = ROWS - 1;
               report.scrolled = 1'b1;
            end
         end
         report.cursor_col = COL_W'(col);
         report.cursor_row = ROW_W'(row);
         report.cursor_offset = ADDR_W'(row * COLS + col);
         pending_reports.push_back(report);
      endfunction

      function void check_field(string field, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         end
      endfunction

      function void compare_report(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_reports.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            return;
         end
         want = pending_reports.pop_front();
         check_field("cell_data", want.cell_data, got.cell_data);
         check_field("cursor_col", 16'(want.cursor_col), 16'(got.cursor_col));
         check_field("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
         check_field("cursor_offset", 16'(want.cursor_offset), 16'(got.cursor_offset));
         check_field("scrolled", 16'(want.scrolled), 16'(got.scrolled));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_write_enable = 1'b0;
   logic csr_index = CSR_TEXT_ATTR;
   logic [7:0] csr_wdata = 8'h00;

   console_mirror mirror;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned holds_asked = 0;
   int unsigned holds_granted = 0;
   int unsigned hold_left = 0;

   text_console_put_char u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver either stalls at random or serves a long hold-off that the main
   // sequence has asked for, counting the hold-off down here.
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_granted != holds_asked) begin
         rsp_stall <= 1'b1;
         holds_granted <= holds_granted + 1;
         hold_left <= 300;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         mirror.compare_report(rsp_payload);
      end
   end

   // Called at a falling edge; returns at a falling edge with valid still high.
   task automatic send_item(input req_payload_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      mirror.apply_item(item);
      @(negedge clock);
   endtask

   task automatic put_char(input logic [7:0] code);
      req_payload_type item;
      item.operation = OP_PUT;
      item.char_code = code;
      item.cell_address = ADDR_W'($urandom_range(2047));
      send_item(item);
   endtask

   task automatic read_cell(input int unsigned address);
      req_payload_type item;
      item.operation = OP_READ;
      item.char_code = 8'($urandom_range(255));
      item.cell_address = ADDR_W'(address);
      send_item(item);
   endtask

   task automatic write_attributes(input logic [7:0] text_value, input logic [7:0] blank_value);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_TEXT_ATTR;
      csr_wdata <= text_value;
      @(posedge clock);
      @(negedge clock);
      csr_index <= CSR_BLANK_ATTR;
      csr_wdata <= blank_value;
      @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      mirror.text_attr = text_value;
      mirror.blank_attr = blank_value;
   endtask

   // The last item has already been taken, so the input goes idle before draining.
   task automatic wait_for_reports;
      req_valid <= 1'b0;
      while (mirror.pending_reports.size() != 0) @(negedge clock);
   endtask

   // Mostly text with cursor controls; reads favor the cells around the cursor and the
   // bottom rows, where scrolls leave their marks, and a few fall past the store.
   function automatic req_payload_type random_item();
      req_payload_type item;
      int unsigned pick;
      int unsigned here;
      item.operation = OP_PUT;
      item.char_code = 8'($urandom_range(255));
      item.cell_address = ADDR_W'($urandom_range(2047));
      pick = $urandom_range(99);
      if (pick < 25) begin
         item.operation = OP_READ;
         here = mirror.row * COLS + mirror.col;
         pick = $urandom_range(99);
         if (pick < 35) begin
            item.cell_address = ADDR_W'(here - $urandom_range(here < 3 ? here : 3));
         end else if (pick < 55) begin
            item.cell_address = ADDR_W'(LAST_ROW_BASE - COLS + $urandom_range(2 * COLS - 1));
         end else if (pick < 90) begin
            item.cell_address = ADDR_W'($urandom_range(CELLS - 1));
         end else begin
            item.cell_address = ADDR_W'($urandom_range(2047, CELLS));
         end
      end else begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            item.char_code = CHAR_NEWLINE;
         end else if (pick < 16) begin
            item.char_code = CHAR_BACKSPACE;
         end else if (pick < 24) begin
            item.char_code = CHAR_TAB;
         end else if (pick < 84) begin
            item.char_code = 8'($urandom_range(8'h7E, 8'h20));
         end
      end
      return item;
   endfunction

   initial begin
      mirror = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 16;
      recv_idle_pct = 56;

      // Directed part at the reset attributes.
      put_char(CHAR_BACKSPACE);
      put_char(8'h00);
      put_char(8'hFF);
      read_cell(0);
      read_cell(1);
      put_char(CHAR_BACKSPACE);
      put_char(CHAR_NEWLINE);
      put_char(CHAR_BACKSPACE);
      put_char(CHAR_BACKSPACE);
      put_char(8'h80);
      put_char(CHAR_TAB);
      put_char(CHAR_BACKSPACE);
      // Ten tabs from column 7 end past the right edge, at column 7 of the next row.
      repeat (10) put_char(CHAR_TAB);
      read_cell(COLS - 1);
      read_cell(CELLS - 1);
      read_cell(CELLS);
      read_cell(2047);

      for (int phase = 0; phase < 4; phase++) begin
         wait_for_reports();
         case (phase)
            0: write_attributes(8'hFF, 8'h00);
            1: write_attributes(8'h00, 8'hFF);
            default: write_attributes(8'($urandom_range(255)), 8'($urandom_range(255)));
         endcase
         case (phase)
            0: begin
               send_idle_pct = 16;
               recv_idle_pct = 56;
            end
            1: begin
               send_idle_pct = 56;
               recv_idle_pct = 16;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if (phase == 2) begin
            holds_asked = holds_asked + 1;
         end
         repeat (285) send_item(random_item());
      end

      wait_for_reports();
      repeat (50) @(negedge clock);
      if (mirror.errors == 0 && mirror.pending_reports.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
